[rtl/tga_rle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

    localparam int BYTE_W      = 8;
    localparam int PIXEL_W     = 32;
    localparam int COUNT_W     = 8;
    localparam int BPP_W       = 3;
    localparam int TOTAL_W     = 25;
    localparam int IDX_W       = 2;
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] RUN_FLAG_MIN = 8'd128;
    localparam logic [BYTE_W-1:0] RUN_BIAS     = 8'd127;

    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd1;

    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_PIXELS    = 1'd1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LITERAL,
        PH_RUN
    } phase_t;

    // one completed pixel as seen by the front part
    typedef struct packed {
        logic               start;
        logic               literal;
        logic [COUNT_W-1:0] need;
        logic [PIXEL_W-1:0] value;
    } pix_evt_t;

endpackage
`default_nettype wire

[rtl/tga_rle_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_in_if
// Byte stream channel into the decoder.
// ----------------------------------------------------------------------------
interface tga_rle_in_if
    import tga_rle_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    logic              image_start;

    modport source (output valid, output stream_byte, output image_start, input ready);
    modport sink   (input valid, input stream_byte, input image_start, output ready);
endinterface
`default_nettype wire

[rtl/tga_rle_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_out_if
// Decoded pixel channel out of the decoder.
// ----------------------------------------------------------------------------
interface tga_rle_out_if
    import tga_rle_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_value;
    logic [COUNT_W-1:0] repeat_count;
    logic               last_pixel;
    logic               overrun_error;

    modport source (output valid, output pixel_value, output repeat_count,
                    output last_pixel, output overrun_error, input ready);
    modport sink   (input valid, input pixel_value, input repeat_count,
                    input last_pixel, input overrun_error, output ready);
endinterface
`default_nettype wire

[rtl/tga_rle_pixel_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Run-length decoder for TGA pixel data, one stream byte per cycle while ready is high.
// ----------------------------------------------------------------------------
// path: a finished pixel item is written into the queue, then registered in the back part
// throughput: one byte per cycle while the two-entry queue has room; the back
//   retires one pixel item per cycle while its output register is free or taken
// stalls: ready drops only while the queue holds two items behind a held result
// reset: bytes_per_pixel 4, total_pixels 1, decoder waits for a packet header
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top
    import tga_rle_pkg::*;
#(
    parameter int MAX_PIXEL_BITS = 24
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    tga_rle_in_if.sink                  pix_in,
    tga_rle_out_if.source               pix_out
);

    logic [BPP_W-1:0]   bpp_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic     accept;
    logic     push;
    pix_evt_t push_evt;
    logic     q_full;
    logic     pop;
    logic     head_valid;
    pix_evt_t head_evt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= BPP_RESET;
            total_reg <= TOTAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BYTES_PER_PIXEL: bpp_reg   <= cfg_wdata[BPP_W-1:0];
                REG_TOTAL_PIXELS:    total_reg <= cfg_wdata[TOTAL_W-1:0];
                default:             ;
            endcase
        end
    end

    assign pix_in.ready = !q_full;
    assign accept       = pix_in.valid && !q_full;

    tga_rle_front #(
        .MAX_PIXEL_BITS (MAX_PIXEL_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .stream_byte     (pix_in.stream_byte),
        .image_start     (pix_in.image_start),
        .bytes_per_pixel (bpp_reg),
        .push            (push),
        .push_evt        (push_evt)
    );

    tga_rle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_evt   (push_evt),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_evt   (head_evt)
    );

    tga_rle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_evt     (head_evt),
        .pop          (pop),
        .total_pixels (total_reg),
        .out_valid    (pix_out.valid),
        .out_ready    (pix_out.ready),
        .out_value    (pix_out.pixel_value),
        .out_count    (pix_out.repeat_count),
        .out_last     (pix_out.last_pixel),
        .out_over     (pix_out.overrun_error)
    );

endmodule
`default_nettype wire

[rtl/tga_rle_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_front
// Packet header parsing and pixel byte assembly; emits one item per pixel.
// ----------------------------------------------------------------------------
module tga_rle_front
    import tga_rle_pkg::*;
#(
    parameter int MAX_PIXEL_BITS = 24
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [BYTE_W-1:0] stream_byte,
    input  wire logic             image_start,
    input  wire logic [BPP_W-1:0] bytes_per_pixel,
    output      logic             push,
    output      pix_evt_t         push_evt
);

    localparam int LIM_RAW = MAX_PIXEL_BITS / 8;
    localparam int LIM     = (LIM_RAW < 1) ? 1 : ((LIM_RAW > 4) ? 4 : LIM_RAW);
    localparam int ASM_W   = LIM * BYTE_W;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ASM_W-1:0]   asm_reg, asm_next;
    logic               pend_reg, pend_next;

    phase_t             phase_eff;
    logic [COUNT_W-1:0] left_eff;
    logic [COUNT_W-1:0] left_dec;
    logic [IDX_W-1:0]   idx_eff;
    logic [ASM_W-1:0]   asm_eff;
    logic [ASM_W-1:0]   asm_new;
    logic [BPP_W-1:0]   width;
    logic               pixel_done;
    logic               is_header;

    // effective pixel width, clamped to 1..LIM
    always_comb
    begin
        if (bytes_per_pixel == '0)
            width = BPP_W'(1);
        else if (bytes_per_pixel > BPP_W'(LIM))
            width = BPP_W'(LIM);
        else
            width = bytes_per_pixel;
    end

    // a start byte wipes the context before it is parsed as a header
    assign phase_eff = image_start ? PH_HEADER : phase_reg;
    assign left_eff  = image_start ? '0 : left_reg;
    assign idx_eff   = image_start ? '0 : idx_reg;
    assign asm_eff   = image_start ? '0 : asm_reg;
    assign left_dec  = left_eff - COUNT_W'(1);

    assign is_header  = (phase_eff == PH_HEADER);
    assign asm_new    = asm_eff | (ASM_W'(stream_byte) << {idx_eff, 3'b000});
    assign pixel_done = !is_header && ({1'b0, idx_eff} + 3'd1 >= width);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_eff)
                PH_HEADER:
                    phase_next = (stream_byte < RUN_FLAG_MIN) ? PH_LITERAL : PH_RUN;
                PH_LITERAL:
                    if (pixel_done && left_dec == '0)
                        phase_next = PH_HEADER;
                    else
                        phase_next = PH_LITERAL;
                PH_RUN:
                    phase_next = pixel_done ? PH_HEADER : PH_RUN;
                default:
                    phase_next = PH_HEADER;
            endcase
        end
    end

    // counters, assembly and the outgoing item
    always_comb
    begin
        left_next = left_reg;
        idx_next  = idx_reg;
        asm_next  = asm_reg;
        pend_next = pend_reg;
        push      = 1'b0;
        push_evt.start   = pend_reg | image_start;
        push_evt.literal = (phase_eff == PH_LITERAL);
        push_evt.need    = left_eff;
        push_evt.value   = PIXEL_W'(asm_new);
        if (accept)
        begin
            if (is_header)
            begin
                left_next = (stream_byte < RUN_FLAG_MIN) ? stream_byte + 8'd1
                                                        : stream_byte - RUN_BIAS;
                idx_next  = '0;
                asm_next  = '0;
                pend_next = pend_reg | image_start;
            end
            else if (!pixel_done)
            begin
                left_next = left_eff;
                idx_next  = idx_eff + IDX_W'(1);
                asm_next  = asm_new;
                pend_next = pend_reg | image_start;
            end
            else
            begin
                push      = 1'b1;
                left_next = (phase_eff == PH_LITERAL) ? left_dec : '0;
                idx_next  = '0;
                asm_next  = '0;
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            left_reg  <= '0;
            idx_reg   <= '0;
            asm_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            asm_reg   <= asm_next;
            pend_reg  <= pend_next;
        end
    end

endmodule
`default_nettype wire

[rtl/tga_rle_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_queue
// Short queue of pixel items between the front and back parts.
// ----------------------------------------------------------------------------
module tga_rle_queue
    import tga_rle_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire pix_evt_t push_evt,
    output      logic     full,
    input  wire logic     pop,
    output      logic     head_valid,
    output      pix_evt_t head_evt
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pix_evt_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_evt   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_evt;
    end

endmodule
`default_nettype wire

[rtl/tga_rle_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_back
// Counts pixels against the image total, clips overruns, registers results.
// ----------------------------------------------------------------------------
module tga_rle_back
    import tga_rle_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire pix_evt_t           head_evt,
    output      logic               pop,
    input  wire logic [TOTAL_W-1:0] total_pixels,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [PIXEL_W-1:0] out_value,
    output      logic [COUNT_W-1:0] out_count,
    output      logic               out_last,
    output      logic               out_over
);

    logic [TOTAL_W-1:0] done_cnt_reg, done_cnt_next;
    logic               stop_reg, stop_next;
    logic               ov_reg, ov_next;
    logic [PIXEL_W-1:0] value_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               last_reg;
    logic               over_reg;

    logic [TOTAL_W-1:0] done_eff;
    logic               stop_eff;
    logic [TOTAL_W-1:0] rem;
    logic [TOTAL_W-1:0] need_ext;
    logic [COUNT_W-1:0] count;
    logic               over;
    logic               last;
    logic               out_free;
    logic               emit;

    assign done_eff = head_evt.start ? '0 : done_cnt_reg;
    assign stop_eff = head_evt.start ? 1'b0 : stop_reg;
    assign rem      = (total_pixels > done_eff) ? total_pixels - done_eff : '0;
    assign need_ext = TOTAL_W'(head_evt.need);

    // a run clipped by the total never exceeds the 8-bit run length
    always_comb
    begin
        if (head_evt.literal)
            count = (rem != '0) ? COUNT_W'(1) : '0;
        else if (need_ext < rem)
            count = head_evt.need;
        else
            count = rem[COUNT_W-1:0];
    end

    assign over     = need_ext > rem;
    assign last     = (TOTAL_W'(count) == rem);
    assign out_free = !ov_reg || out_ready;
    // items after the image is finished are dropped without waiting
    assign pop      = head_valid && (stop_eff || out_free);
    assign emit     = head_valid && !stop_eff && out_free;

    always_comb
    begin
        done_cnt_next = done_cnt_reg;
        stop_next     = stop_reg;
        ov_next       = ov_reg;
        if (out_ready)
            ov_next = 1'b0;
        if (pop)
        begin
            done_cnt_next = done_eff;
            stop_next     = stop_eff;
        end
        if (emit)
        begin
            done_cnt_next = done_eff + TOTAL_W'(count);
            stop_next     = over || last;
            ov_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_cnt_reg <= '0;
            stop_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            done_cnt_reg <= done_cnt_next;
            stop_reg     <= stop_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg <= head_evt.value;
            count_reg <= count;
            last_reg  <= last;
            over_reg  <= over;
        end
    end

    assign out_valid = ov_reg;
    assign out_value = value_reg;
    assign out_count = count_reg;
    assign out_last  = last_reg;
    assign out_over  = over_reg;

endmodule
`default_nettype wire

[tb/tga_rle_pixel_decoder_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top_test
// Self-checking bench for the TGA run-length decoder: a short table of
// directed bytes and register writes, then random images under three idle
// patterns, every decoded pixel compared with typed values or a local decoder copy.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top_test
    import tga_rle_pkg::*;
;

    localparam int MAX_PIXEL_BITS = 24;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_BYTES    = 95;

    typedef struct packed {
        logic [PIXEL_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               over;
    } pixel_result_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_SET_BPP,
        ROW_SET_TOTAL
    } row_kind_t;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_PIXEL
    } check_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  start;
        logic [CFG_DATA_W-1:0] data;
        check_t                check;
        pixel_result_t         pix;
    } stim_row_t;

    localparam pixel_result_t NO_PIXEL = '0;

    localparam stim_row_t DIRECTED [33] = '{
        // reset defaults: width clamps to 3 bytes, one pixel in the image
        '{ROW_BYTE,      1'b0, 25'h081,     CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h0FF,     CHK_MODEL, NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h000,     CHK_MODEL, NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h0A5,     CHK_PIXEL, '{32'h00A5_00FF, 8'd1, 1'b1, 1'b1}},
        // image complete, byte dropped
        '{ROW_BYTE,      1'b0, 25'h012,     CHK_NONE,  NO_PIXEL},
        '{ROW_SET_BPP,   1'b0, 25'd1,       CHK_NONE,  NO_PIXEL},
        '{ROW_SET_TOTAL, 1'b0, 25'h1FFFFFF, CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b1, 25'h000,     CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h0FF,     CHK_PIXEL, '{32'h0000_00FF, 8'd1, 1'b0, 1'b0}},
        '{ROW_BYTE,      1'b0, 25'h07F,     CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h000,     CHK_PIXEL, '{32'h0000_0000, 8'd1, 1'b0, 1'b0}},
        '{ROW_BYTE,      1'b0, 25'h080,     CHK_PIXEL, '{32'h0000_0080, 8'd1, 1'b0, 1'b0}},
        // restart in the middle of a literal, longest run
        '{ROW_BYTE,      1'b1, 25'h0FF,     CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h05A,     CHK_PIXEL, '{32'h0000_005A, 8'd128, 1'b0, 1'b0}},
        '{ROW_BYTE,      1'b0, 25'h080,     CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h001,     CHK_PIXEL, '{32'h0000_0001, 8'd1, 1'b0, 1'b0}},
        // width 0 acts as 1, total now below the pixels already done
        '{ROW_SET_BPP,   1'b0, 25'd0,       CHK_NONE,  NO_PIXEL},
        '{ROW_SET_TOTAL, 1'b0, 25'd3,       CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h000,     CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h033,     CHK_PIXEL, '{32'h0000_0033, 8'd0, 1'b1, 1'b1}},
        '{ROW_BYTE,      1'b1, 25'h082,     CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h044,     CHK_PIXEL, '{32'h0000_0044, 8'd3, 1'b1, 1'b0}},
        // width raised, then lowered, in the middle of a pixel
        '{ROW_SET_BPP,   1'b0, 25'd2,       CHK_NONE,  NO_PIXEL},
        '{ROW_SET_TOTAL, 1'b0, 25'd1000,    CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b1, 25'h000,     CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h011,     CHK_MODEL, NO_PIXEL},
        '{ROW_SET_BPP,   1'b0, 25'd3,       CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h022,     CHK_MODEL, NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h033,     CHK_MODEL, NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h000,     CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h0AA,     CHK_MODEL, NO_PIXEL},
        '{ROW_SET_BPP,   1'b0, 25'd1,       CHK_NONE,  NO_PIXEL},
        '{ROW_BYTE,      1'b0, 25'h0BB,     CHK_MODEL, NO_PIXEL}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    tga_rle_in_if  pix_in ();
    tga_rle_out_if pix_out ();

    tga_rle_pixel_decoder_top #(
        .MAX_PIXEL_BITS (MAX_PIXEL_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pix_in    (pix_in),
        .pix_out   (pix_out)
    );

    // local decoder state
    logic [BPP_W-1:0]   dec_bpp        = BPP_RESET;
    logic [TOTAL_W-1:0] dec_total      = TOTAL_RESET;
    phase_t             dec_phase      = PH_HEADER;
    bit                 dec_stopped    = 1'b0;
    logic [COUNT_W-1:0] dec_left       = '0;
    logic [IDX_W-1:0]   dec_byte_idx   = '0;
    logic [PIXEL_W-1:0] dec_acc        = '0;
    logic [TOTAL_W-1:0] dec_done_count = '0;

    pixel_result_t pending_pixels [$];
    int unsigned   pixel_errors   = 0;
    int unsigned   bytes_decoded  = 0;
    int unsigned   sender_idle_pct   = 37;
    int unsigned   receiver_idle_pct = 76;

    always #6 clk = ~clk;

    function automatic int effective_width();
        int lim;
        int w;
        lim = MAX_PIXEL_BITS / 8;
        if (lim < 1) lim = 1;
        if (lim > 4) lim = 4;
        w = int'(dec_bpp);
        if (w < 1) w = 1;
        if (w > lim) w = lim;
        return w;
    endfunction

    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic s,
                                       output pixel_result_t res, output bit ignored);
        logic [TOTAL_W-1:0] remaining;
        logic [COUNT_W-1:0] count;
        bit                 over;
        bit                 last;
        res     = '0;
        ignored = 1'b0;
        if (s)
        begin
            dec_phase      = PH_HEADER;
            dec_stopped    = 1'b0;
            dec_left       = '0;
            dec_byte_idx   = '0;
            dec_acc        = '0;
            dec_done_count = '0;
        end
        if (dec_stopped)
        begin
            ignored = 1'b1;
            return 1'b0;
        end
        if (dec_phase == PH_HEADER)
        begin
            if (b < RUN_FLAG_MIN)
            begin
                dec_left  = b + 8'd1;
                dec_phase = PH_LITERAL;
            end
            else
            begin
                dec_left  = b - RUN_BIAS;
                dec_phase = PH_RUN;
            end
            dec_byte_idx = '0;
            dec_acc      = '0;
            return 1'b0;
        end
        dec_acc = dec_acc | (PIXEL_W'(b) << (8 * dec_byte_idx));
        if (int'(dec_byte_idx) + 1 < effective_width())
        begin
            dec_byte_idx = dec_byte_idx + 1'b1;
            return 1'b0;
        end
        remaining = (dec_total > dec_done_count) ? dec_total - dec_done_count : '0;
        if (dec_phase == PH_LITERAL)
            count = (remaining >= 1) ? COUNT_W'(1) : COUNT_W'(0);
        else
            count = (TOTAL_W'(dec_left) < remaining) ? dec_left : COUNT_W'(remaining);
        over = TOTAL_W'(dec_left) > remaining;
        last = TOTAL_W'(count) == remaining;
        res  = '{value: dec_acc, count: count, last: last, over: over};
        dec_done_count = dec_done_count + TOTAL_W'(count);
        dec_byte_idx   = '0;
        dec_acc        = '0;
        if (over || last)
        begin
            dec_stopped = 1'b1;
            dec_left    = '0;
        end
        else if (dec_phase == PH_LITERAL)
        begin
            dec_left = dec_left - 1'b1;
            if (dec_left == 0)
                dec_phase = PH_HEADER;
        end
        else
        begin
            dec_left  = '0;
            dec_phase = PH_HEADER;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string field,
                                        input logic [PIXEL_W-1:0] want_v,
                                        input logic [PIXEL_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want_v, got_v);
            pixel_errors++;
        end
    endfunction

    // called and returning at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s,
                             input check_t chk, input pixel_result_t typed);
        pixel_result_t predicted;
        bit            has_pixel;
        bit            ignored;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.stream_byte <= b;
        pix_in.image_start <= s;
        do
            @(posedge clk);
        while (!pix_in.ready);
        has_pixel = decode_byte(b, s, predicted, ignored);
        case (chk)
            CHK_PIXEL: pending_pixels.push_back(typed);
            CHK_MODEL: if (has_pixel) pending_pixels.push_back(predicted);
            default: ;
        endcase
        if (!ignored)
            bytes_decoded++;
        @(negedge clk);
    endtask

    // registers change only with the decoder drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        pix_in.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_BYTES_PER_PIXEL)
            dec_bpp = value[BPP_W-1:0];
        else
            dec_total = value[TOTAL_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] random_header();
        case ($urandom_range(0, 9))
            0:          return BYTE_W'($urandom_range(0, 255));
            1, 2, 3, 4: return BYTE_W'($urandom_range(0, 5));
            default:    return BYTE_W'(RUN_FLAG_MIN + $urandom_range(0, 20));
        endcase
    endfunction

    task automatic send_packet(input logic [BYTE_W-1:0] hdr, input logic s);
        int unsigned npix;
        npix = (hdr < RUN_FLAG_MIN) ? int'(hdr) + 1 : 1;
        send_byte(hdr, s, CHK_MODEL, NO_PIXEL);
        for (int unsigned p = 0; p < npix && !dec_stopped; p++)
        begin
            // cut short now and then so the next header lands as pixel data
            if ($urandom_range(0, 59) == 0)
                return;
            for (int k = 0; k < effective_width(); k++)
                send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, CHK_MODEL, NO_PIXEL);
        end
    endtask

    task automatic send_image();
        int unsigned packets;
        packets = $urandom_range(1, 10);
        send_packet(random_header(), 1'b1);
        for (int unsigned p = 1; p < packets && !dec_stopped; p++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0),
                          CHK_MODEL, NO_PIXEL);
            else
                send_packet(random_header(), 1'b0);
        end
        // trailing bytes after a complete image are dropped
        if (dec_stopped && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, CHK_MODEL, NO_PIXEL);
    endtask

    always @(negedge clk)
        pix_out.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    always @(posedge clk)
    begin : watch_pixels
        pixel_result_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t ns: pixel expected none, got value %0h count %0d",
                         $time, pix_out.pixel_value, pix_out.repeat_count);
                pixel_errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_value", want.value, pix_out.pixel_value);
                check_field("repeat_count", PIXEL_W'(want.count), PIXEL_W'(pix_out.repeat_count));
                check_field("last_pixel", PIXEL_W'(want.last), PIXEL_W'(pix_out.last_pixel));
                check_field("overrun_error", PIXEL_W'(want.over),
                            PIXEL_W'(pix_out.overrun_error));
            end
        end
    end

    initial
    begin
        logic [BPP_W-1:0]   bpp_sel;
        logic [TOTAL_W-1:0] total_sel;
        int unsigned        target;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_BYTES_PER_PIXEL;
        cfg_wdata          = '0;
        pix_in.valid       = 1'b0;
        pix_in.stream_byte = '0;
        pix_in.image_start = 1'b0;
        pix_out.ready      = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
        begin
            case (DIRECTED[i].kind)
                ROW_SET_BPP:   write_reg(REG_BYTES_PER_PIXEL, DIRECTED[i].data);
                ROW_SET_TOTAL: write_reg(REG_TOTAL_PIXELS, DIRECTED[i].data);
                default:       send_byte(DIRECTED[i].data[BYTE_W-1:0], DIRECTED[i].start,
                                         DIRECTED[i].check, DIRECTED[i].pix);
            endcase
        end

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph / 3)
                0:       begin sender_idle_pct = 37; receiver_idle_pct = 76; end
                1:       begin sender_idle_pct = 76; receiver_idle_pct = 37; end
                default: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
            endcase
            case (ph)
                0:       bpp_sel = 3'd7;
                1:       bpp_sel = 3'd0;
                default: bpp_sel = BPP_W'($urandom_range(0, 7));
            endcase
            case (ph)
                2:       total_sel = 25'd16777216;
                3:       total_sel = 25'd1;
                default:
                    case ($urandom_range(0, 9))
                        0:          total_sel = '0;
                        1:          total_sel = TOTAL_W'($urandom);
                        2, 3, 4, 5: total_sel = TOTAL_W'($urandom_range(1, 8));
                        default:    total_sel = TOTAL_W'($urandom_range(9, 400));
                    endcase
            endcase
            write_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'(bpp_sel));
            write_reg(REG_TOTAL_PIXELS, CFG_DATA_W'(total_sel));
            target = bytes_decoded + PHASE_BYTES;
            while (bytes_decoded < target)
                send_image();
        end

        pix_in.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pixel_errors == 0)
            $display("tga_rle_pixel_decoder_top_test OK");
        else
            $display("tga_rle_pixel_decoder_top_test NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tga_rle_pixel_decoder_top_test NOT OK");
        $finish;
    end

endmodule

[files.f]
rtl/tga_rle_pkg.sv
rtl/tga_rle_in_if.sv
rtl/tga_rle_out_if.sv
rtl/tga_rle_front.sv
rtl/tga_rle_queue.sv
rtl/tga_rle_back.sv
rtl/tga_rle_pixel_decoder_top.sv
tb/tga_rle_pixel_decoder_top_test.sv
